// ===== sv/dgd_pkg.sv =====
// ----------------------------------------------------------------------------
// dgd_pkg
// Shared types and constants of the double-Gaussian density unit.
// ----------------------------------------------------------------------------
package dgd_pkg;

  localparam int unsigned SeriesTerms = 20;

  localparam logic [64:0] ExpLimit    = 65'd40 << 32;
  localparam logic [31:0] Log2eQ31    = 32'hB8AA_3B29;
  localparam logic [31:0] Ln2Q32      = 32'hB172_17F8;
  localparam logic [60:0] OneQ60      = 61'd1 << 60;
  localparam logic [49:0] Mask48      = {2'b00, {48{1'b1}}};
  localparam logic [16:0] FullFraction = 17'd65536;

  typedef enum logic [2:0] {
    RegMeanMass      = 3'd0,
    RegFractionFirst = 3'd1,
    RegExpCoefFirst  = 3'd2,
    RegExpCoefSecond = 3'd3,
    RegNormFirst     = 3'd4,
    RegNormSecond    = 3'd5,
    RegComponentSel  = 3'd6,
    RegUnused        = 3'd7
  } reg_index_t;

  localparam logic [1:0] SelSum    = 2'd0;
  localparam logic [1:0] SelFirst  = 2'd1;
  localparam logic [1:0] SelSecond = 2'd2;

  // one beat of the exp series as it moves from term to term
  typedef struct packed {
    logic        valid;
    logic        zero;
    logic [5:0]  n;
    logic [31:0] u;
    logic [60:0] term;
    logic [63:0] sum;
  } series_t;

endpackage

// ===== sv/dgd_term.sv =====
// ----------------------------------------------------------------------------
// dgd_term
// One Taylor step: term = (term * u >> 32) / K, then add or subtract it.
// ----------------------------------------------------------------------------
module dgd_term import dgd_pkg::*; #(
  parameter int unsigned K = 1
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  series_t in_s,
  output series_t out_s
);

  // floor((2^64-1)/K): quotient estimate is off by at most one, fixed below
  localparam logic [63:0] Recip = 64'hFFFF_FFFF_FFFF_FFFF / 64'(K);
  localparam logic [4:0]  Div   = 5'(K);

  series_t s1, s2, s3, s4;
  series_t out_next;
  logic [60:0] ph1;
  logic [31:0] pl1;
  logic [60:0] m2, m3, m4;
  logic [60:0] p_hh, p_hl;
  logic [63:0] p_lh, p_ll;
  logic [60:0] q4;

  logic [63:0] lo_full;
  logic [65:0] mid;
  logic [65:0] q0_full;
  logic [65:0] qk;
  logic [65:0] rem;
  logic [60:0] q;
  logic [63:0] sum_next;

  assign lo_full = 64'(in_s.term[31:0]) * 64'(in_s.u);
  assign mid     = 66'(p_hl) + 66'(p_lh) + 66'(p_ll[63:32]);
  assign q0_full = 66'(p_hh) + (mid >> 32);
  assign qk      = 66'(q4) * 66'(Div);
  assign rem     = 66'(m4) - qk;
  assign q       = (rem >= 66'(Div)) ? q4 + 61'd1 : q4;
  assign sum_next = K[0] ? s4.sum - 64'(q) : s4.sum + 64'(q);

  always_comb begin
    out_next      = s4;
    out_next.term = q;
    out_next.sum  = sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid    <= 1'b0;
      s2.valid    <= 1'b0;
      s3.valid    <= 1'b0;
      s4.valid    <= 1'b0;
      out_s.valid <= 1'b0;
    end else if (en) begin
      s1   <= in_s;
      ph1  <= 61'(in_s.term[60:32]) * 61'(in_s.u);
      pl1  <= lo_full[63:32];
      s2   <= s1;
      m2   <= ph1 + 61'(pl1);
      s3   <= s2;
      m3   <= m2;
      p_hh <= 61'(m2[60:32]) * 61'(Recip[63:32]);
      p_hl <= 61'(m2[60:32]) * 61'(Recip[31:0]);
      p_lh <= 64'(m2[31:0]) * 64'(Recip[63:32]);
      p_ll <= 64'(m2[31:0]) * 64'(Recip[31:0]);
      s4   <= s3;
      m4   <= m3;
      q4   <= q0_full[60:0];
      out_s <= out_next;
    end
  end

endmodule

// ===== sv/dgd_gauss.sv =====
// ----------------------------------------------------------------------------
// dgd_gauss
// One Gaussian lane: exp(-d2 * coef) by range reduction and series, times norm.
// ----------------------------------------------------------------------------
module dgd_gauss import dgd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] d2,
  input  logic [31:0] coef,
  input  logic [31:0] norm,
  output logic        out_valid,
  output logic [48:0] g
);

  logic        v1, v2, v3, v4, v6, v7;
  logic [63:0] t1;
  logic [31:0] lo1;
  logic [37:0] x2;
  logic        z2, z3, z4, z6;
  logic [37:0] yh3;
  logic [32:0] yl3;
  logic [5:0]  n4;
  logic [31:0] r4;
  series_t     head;
  logic [60:0] e6;
  logic [60:0] eh7;
  logic [31:0] el7;

  logic [63:0] lo_full;
  logic [64:0] x_full;
  logic [63:0] yl_full;
  logic [38:0] y_full;
  logic [63:0] u_full;
  logic [63:0] el_full;
  logic [60:0] g_full;

  series_t chain [SeriesTerms+1];

  assign lo_full = 64'(d2[31:0]) * 64'(coef);
  assign x_full  = 65'(t1) + 65'(lo1);
  assign yl_full = 64'(x2[31:0]) * 64'(Log2eQ31);
  assign y_full  = {1'b0, yh3} + 39'(yl3);
  assign u_full  = 64'(r4) * 64'(Ln2Q32);
  assign el_full = 64'(e6[31:0]) * 64'(norm);
  assign g_full  = eh7 + 61'(el7);

  always_comb begin
    head.valid = v4;
    head.zero  = z4;
    head.n     = n4;
    head.u     = u_full[63:32];
    head.term  = OneQ60;
    head.sum   = 64'(OneQ60);
  end

  assign chain[0] = head;

  // register the series head so the u multiply has a stage of its own
  series_t s5;
  always_ff @(posedge clk) begin
    if (rst) s5.valid <= 1'b0;
    else if (en) s5 <= chain[0];
  end

  for (genvar k = 1; k <= SeriesTerms; k++) begin : g_term
    if (k == 1) begin : g_first
      dgd_term #(.K(k)) u_term (
        .clk(clk), .rst(rst), .en(en), .in_s(s5), .out_s(chain[k])
      );
    end else begin : g_rest
      dgd_term #(.K(k)) u_term (
        .clk(clk), .rst(rst), .en(en), .in_s(chain[k-1]), .out_s(chain[k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1  <= in_valid;
      t1  <= 64'(d2[63:32]) * 64'(coef);
      lo1 <= lo_full[63:32];
      v2  <= v1;
      x2  <= x_full[37:0];
      z2  <= x_full > ExpLimit;
      v3  <= v2;
      z3  <= z2;
      yh3 <= {38'(x2[37:32]) * 38'(Log2eQ31)} << 1;
      yl3 <= yl_full[63:31];
      v4  <= v3;
      z4  <= z3;
      n4  <= y_full[37:32];
      r4  <= y_full[31:0];
      v6  <= chain[SeriesTerms].valid;
      z6  <= chain[SeriesTerms].zero;
      e6  <= (chain[SeriesTerms].zero || chain[SeriesTerms].n >= 6'd63) ? 61'd0
             : chain[SeriesTerms].sum[60:0] >> chain[SeriesTerms].n;
      v7  <= v6;
      eh7 <= 61'(e6[60:32]) * 61'(norm);
      el7 <= el_full[63:32];
      out_valid <= v7;
      g   <= g_full[60:12];
    end
  end

  // an overflowed argument must leave the lane as zero
  assert property (@(posedge clk) disable iff (rst)
    v6 && z6 |-> e6 == 61'd0)
    else $error("dgd_gauss: overflowed argument gave nonzero exp");

endmodule

// ===== sv/double_gaussian_density_unit.sv =====
// ----------------------------------------------------------------------------
// double_gaussian_density_unit
// Double-Gaussian density of one mass sample per beat, fixed point.
// ----------------------------------------------------------------------------
// Path: the 20-step exp series, five register stages per step, in each Gaussian
//   lane lies between input beat and result.
// Throughput: one sample per cycle; a stalled output holds the whole pipeline.
// Reset (rst, synchronous): clears all valid bits and loads the register
//   defaults; configuration is always ready.
module double_gaussian_density_unit import dgd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] mass,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] density,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] mean_mass;
  logic [16:0] fraction_first;
  logic [31:0] exp_coef_first;
  logic [31:0] exp_coef_second;
  logic [31:0] norm_first;
  logic [31:0] norm_second;
  logic [1:0]  component_select;

  logic        en;
  logic        v0, v1, vw;
  logic [31:0] d0;
  logic [63:0] d2;
  logic        g1_valid, g2_valid;
  logic [48:0] g1, g2;
  logic [48:0] g1w, w1, w2;
  logic        full_w;

  logic [64:0] w1_full;
  logic [65:0] w2_full;
  logic [16:0] comp_frac;
  logic [49:0] res;
  logic [47:0] density_next;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_mass        <= 32'd351666176;
      fraction_first   <= FullFraction;
      exp_coef_first   <= '0;
      exp_coef_second  <= '0;
      norm_first       <= '0;
      norm_second      <= '0;
      component_select <= SelSum;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        RegMeanMass:      mean_mass        <= cfg_data;
        RegFractionFirst: fraction_first   <= cfg_data[16:0];
        RegExpCoefFirst:  exp_coef_first   <= cfg_data;
        RegExpCoefSecond: exp_coef_second  <= cfg_data;
        RegNormFirst:     norm_first       <= cfg_data;
        RegNormSecond:    norm_second      <= cfg_data;
        RegComponentSel:  component_select <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  dgd_gauss u_first (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1), .d2(d2),
    .coef(exp_coef_first), .norm(norm_first),
    .out_valid(g1_valid), .g(g1)
  );

  dgd_gauss u_second (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1), .d2(d2),
    .coef(exp_coef_second), .norm(norm_second),
    .out_valid(g2_valid), .g(g2)
  );

  assign comp_frac = FullFraction - {1'b0, fraction_first[15:0]};
  assign w1_full   = 65'(fraction_first[15:0]) * 65'(g1);
  assign w2_full   = 66'(comp_frac) * 66'(g2);

  always_comb begin
    if (full_w) begin
      res = (component_select == SelSecond) ? 50'd0 : 50'(g1w);
    end else begin
      unique case (component_select)
        SelFirst:  res = 50'(w1);
        SelSecond: res = 50'(w2);
        default:   res = 50'(w1) + 50'(w2);
      endcase
    end
    // saturate, then floor at one LSB
    if (res > Mask48) density_next = Mask48[47:0];
    else if (res == 50'd0) density_next = 48'd1;
    else density_next = res[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      vw <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0  <= in_valid;
      d0  <= (mass >= mean_mass) ? mass - mean_mass : mean_mass - mass;
      v1  <= v0;
      d2  <= 64'(d0) * 64'(d0);
      vw  <= g1_valid;
      g1w <= g1;
      w1  <= w1_full[64:16];
      w2  <= w2_full[64:16];
      full_w <= fraction_first[16];
      out_valid <= vw;
      density   <= density_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) g1_valid == g2_valid)
    else $error("lanes out of step");

  assert property (@(posedge clk) disable iff (rst) out_valid |-> density != 48'd0)
    else $error("density below floor");

  assert property (@(posedge clk) rst |=> !out_valid && !vw && !v0)
    else $error("reset left a valid beat");

endmodule
